// ----- hw/rtl/mah_pkg.sv -----
// Package for the moving-average block: window size, field widths and
// sequencer state type. No dependencies.
package mah_pkg;

  localparam int unsigned WINDOW_LENGTH = 16;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned AVG_W    = 23;

  localparam int unsigned SLOT_W = $clog2(WINDOW_LENGTH);
  localparam int unsigned CNT_W  = $clog2(WINDOW_LENGTH + 1);
  localparam int unsigned SUM_W  = SAMPLE_W + CNT_W;

  // 200*sum + count, divided by 2*count, gives the mean in hundredths
  // rounded half up.
  localparam int unsigned SCALE   = 200;
  localparam int unsigned SCALE_W = 8;
  localparam int unsigned NUM_W   = SUM_W + SCALE_W;
  localparam int unsigned DEN_W   = CNT_W + 1;
  localparam int unsigned DCNT_W  = $clog2(NUM_W + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } mah_state_e;

endpackage

// ----- hw/rtl/moving_average_hundredths.sv -----
// Moving average of 16-bit samples, reported in hundredths, rounded half up.
// Depends on mah_pkg (window size, widths, sequencer states).
//
//   channel  | valid       | stall        | payload
//   ---------+-------------+--------------+----------------------------
//   input    | in_valid_i  | in_stall_o   | sample_i [15:0]
//   output   | out_valid_o | out_stall_i  | average_hundredths_o [22:0]
//
// Each sample passes through one ring read, one sum update, one scale
// multiply, NUM_W steps of the restoring divider by 2*count, and one load
// of the output register, which waits while a held result is stalled.
// in_stall_o is high from a transfer until the result is loaded; the output
// register holds the result while out_stall_i is high, and the next sample
// may be taken meanwhile. Reset clears count, sum and ring pointer; the ring
// itself needs no clearing since a value read from it is used only once written.
module moving_average_hundredths (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mah_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mah_pkg::AVG_W-1:0]     average_hundredths_o
);

  mah_pkg::mah_state_e state_q, state_d;

  logic [mah_pkg::SAMPLE_W-1:0] ring_mem [mah_pkg::WINDOW_LENGTH];

  logic [mah_pkg::SAMPLE_W-1:0] sample_q;
  logic [mah_pkg::SAMPLE_W-1:0] oldest_q;
  logic [mah_pkg::SLOT_W-1:0]   slot_q;
  logic [mah_pkg::CNT_W-1:0]    cnt_q;
  logic [mah_pkg::SUM_W-1:0]    sum_q;
  logic [mah_pkg::NUM_W-1:0]    num_q;
  logic [mah_pkg::DEN_W-1:0]    den_q;
  logic [mah_pkg::DEN_W-1:0]    rem_q;
  logic [mah_pkg::DCNT_W-1:0]   dcnt_q;
  logic                         out_valid_q;
  logic [mah_pkg::AVG_W-1:0]    out_q;

  logic                         in_xfer;
  logic                         out_load;
  logic                         win_full;
  logic                         div_last;
  logic [mah_pkg::DEN_W:0]      rem_shift;
  logic                         rem_ge;
  logic [mah_pkg::DEN_W-1:0]    rem_next;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign win_full = (cnt_q == mah_pkg::CNT_W'(mah_pkg::WINDOW_LENGTH));
  assign div_last = (dcnt_q == mah_pkg::DCNT_W'(mah_pkg::NUM_W - 1));

  // One restoring-division step: shift in the next numerator bit, subtract.
  assign rem_shift = {rem_q, num_q[mah_pkg::NUM_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, den_q});
  assign rem_next  = rem_ge ? mah_pkg::DEN_W'(rem_shift - {1'b0, den_q})
                            : rem_shift[mah_pkg::DEN_W-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mah_pkg::ST_IDLE: if (in_xfer) state_d = mah_pkg::ST_SUM;
      mah_pkg::ST_SUM:  state_d = mah_pkg::ST_MUL;
      mah_pkg::ST_MUL:  state_d = mah_pkg::ST_DIV;
      mah_pkg::ST_DIV:  if (div_last) state_d = mah_pkg::ST_DONE;
      mah_pkg::ST_DONE: if (!out_valid_q || !out_stall_i) state_d = mah_pkg::ST_IDLE;
      default:          state_d = mah_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    unique case (state_q)
      mah_pkg::ST_IDLE: in_stall_o = 1'b0;
      mah_pkg::ST_DONE: out_load   = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mah_pkg::ST_IDLE;
      slot_q      <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == mah_pkg::ST_SUM) begin
        // drop the oldest sample once the window is full
        if (win_full) begin
          sum_q <= sum_q - mah_pkg::SUM_W'(oldest_q) + mah_pkg::SUM_W'(sample_q);
        end else begin
          sum_q <= sum_q + mah_pkg::SUM_W'(sample_q);
          cnt_q <= cnt_q + mah_pkg::CNT_W'(1);
        end
        if (slot_q == mah_pkg::SLOT_W'(mah_pkg::WINDOW_LENGTH - 1)) begin
          slot_q <= '0;
        end else begin
          slot_q <= slot_q + mah_pkg::SLOT_W'(1);
        end
      end
      if (state_q == mah_pkg::ST_MUL) begin
        dcnt_q <= '0;
      end else if (state_q == mah_pkg::ST_DIV) begin
        dcnt_q <= dcnt_q + mah_pkg::DCNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sample_q <= sample_i;
    end
    unique case (state_q)
      mah_pkg::ST_MUL: begin
        num_q <= mah_pkg::NUM_W'(sum_q) * mah_pkg::NUM_W'(mah_pkg::SCALE)
                 + mah_pkg::NUM_W'(cnt_q);
        den_q <= {cnt_q, 1'b0};
        rem_q <= '0;
      end
      mah_pkg::ST_DIV: begin
        // quotient bits fill the numerator register from the bottom
        num_q <= {num_q[mah_pkg::NUM_W-2:0], rem_ge};
        rem_q <= rem_next;
      end
      default: ;
    endcase
    if (out_load) begin
      out_q <= num_q[mah_pkg::AVG_W-1:0];
    end
  end

  // Sample ring: read the slot at transfer, overwrite it in the sum cycle
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      oldest_q <= ring_mem[slot_q];
    end
    if (state_q == mah_pkg::ST_SUM) begin
      ring_mem[slot_q] <= sample_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign average_hundredths_o = out_q;

endmodule
